>>> src/ean8r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean8r_pkg
// Shared types and constants for the EAN-8 raster generator.
// ----------------------------------------------------------------------------
package ean8r_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int BAR_HEIGHT = 100;
	localparam int DIM_W      = $clog2(MAX_DIM);	// row / column counter width
	localparam int MODULES    = 67;
	localparam int MOD_W      = 7;			// module index, 0..67
	localparam int OFF_W      = 14;			// signed column offset from the symbol start
	localparam int EXT_W      = 13;			// symbol extent in pixels, up to 67 * 63
	localparam int REG_W      = 32;
	localparam int IDX_W      = 2;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_CODE_DIGITS   = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd2;
	localparam logic [IDX_W-1:0] REG_BAR_THICKNESS = 2'd3;

	// L-code of each digit, leftmost module in bit 6. R-code is the complement.
	localparam logic [6:0] LCODE [16] = '{
		7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B,
		7'h37, 7'h0B, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	// Geometry sequencer run after reset and after every register write.
	typedef enum logic [2:0] {
		ST_GEOM,	// clamp sizes, symbol extent, code check
		ST_LEFT,	// left margin
		ST_START,	// load row-start offset into divider
		ST_DIV,		// one quotient bit per cycle
		ST_POS,		// load current column offset into divider
		ST_RUN		// pixels flow
	} state_t;

endpackage

>>> src/ean8_barcode_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean8_barcode_raster
// EAN-8 barcode image generator, one pixel per accepted word with advance set, raster order.
// ----------------------------------------------------------------------------
// Each pixel word is registered, in the output register or the skid entry.
// Throughput: one word per cycle while s_tready is high; a two-entry output buffer
// keeps s_tready up while one result waits on m_tready.
// Reset (arst_n low, async) loads the register defaults and zeroes the raster
// position; after reset and after each register write the geometry sequencer
// holds s_tready low over the left margin and one or two 7-step divisions.
// ----------------------------------------------------------------------------
module ean8_barcode_raster (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write port
	input  logic                        cfg_we,
	input  logic [ean8r_pkg::IDX_W-1:0] cfg_index,
	input  logic [ean8r_pkg::REG_W-1:0] cfg_data,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,	// [0] advance, [7:1] zero
	// output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,	// [0] pixel_black, [1] row_end,
							// [2] code_valid, [7:3] zero
	output logic                        m_tlast		// image_end
);

	localparam int DIM_W = ean8r_pkg::DIM_W;
	localparam int MOD_W = ean8r_pkg::MOD_W;
	localparam int OFF_W = ean8r_pkg::OFF_W;
	localparam int EXT_W = ean8r_pkg::EXT_W;
	localparam logic [MOD_W-1:0] MOD_OUT = MOD_W'(ean8r_pkg::MODULES);
	localparam logic [12:0] MAXD = 13'(ean8r_pkg::MAX_DIM);
	localparam logic [12:0] BARH = 13'(ean8r_pkg::BAR_HEIGHT);

	// ---------------- configuration registers ----------------
	logic [31:0] code_digits_q;
	logic [12:0] image_width_q;
	logic [12:0] image_height_q;
	logic [5:0]  bar_thickness_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_digits_q   <= '0;
			image_width_q   <= 13'd200;
			image_height_q  <= 13'd100;
			bar_thickness_q <= 6'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ean8r_pkg::REG_CODE_DIGITS:   code_digits_q   <= cfg_data;
				ean8r_pkg::REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[12:0];
				ean8r_pkg::REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[12:0];
				ean8r_pkg::REG_BAR_THICKNESS: bar_thickness_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// ---------------- code check and module pattern ----------------
	// Digit i sits in nibble 7-i (first digit in the top nibble).
	function automatic logic [3:0] digit(input logic [31:0] d, input int i);
		digit = d[31-4*i -: 4];
	endfunction

	// Valid when every nibble is 0..9 and the check digit matches the 3/1 sum.
	function automatic logic code_check(input logic [31:0] d);
		logic        numeric;
		logic [7:0]  sum;
		logic [15:0] prod;
		logic [3:0]  q10;
		logic [7:0]  rem;
		logic [3:0]  want;
		numeric = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (digit(d, i) > 4'd9) numeric = 1'b0;
		end
		sum = 8'd3 * (8'(digit(d, 0)) + 8'(digit(d, 2)) + 8'(digit(d, 4))
			+ 8'(digit(d, 6)))
			+ 8'(digit(d, 1)) + 8'(digit(d, 3)) + 8'(digit(d, 5));
		// sum <= 135: sum / 10 == (sum * 205) >> 11
		prod = 16'(sum) * 16'd205;
		q10  = prod[14:11];
		rem  = sum - 8'(q10) * 8'd10;
		want = (rem == 8'd0) ? 4'd0 : 4'(8'd10 - rem);
		code_check = numeric && (digit(d, 7) == want);
	endfunction

	// Bar value per module, module 0 in bit 0; bit 67 (outside) is white.
	function automatic logic [MOD_W+60:0] build_pattern(input logic [31:0] d);
		logic [MOD_W+60:0] p;
		logic [6:0]        code;
		p = '0;
		p[0] = 1'b1; p[1] = 1'b0; p[2] = 1'b1;
		for (int k = 0; k < 4; k++) begin
			code = ean8r_pkg::LCODE[digit(d, k)];
			for (int j = 0; j < 7; j++) p[3 + 7*k + j] = code[6-j];
		end
		for (int j = 0; j < 5; j++) p[31 + j] = (j % 2 == 1);
		for (int k = 0; k < 4; k++) begin
			code = ~ean8r_pkg::LCODE[digit(d, 4 + k)];
			for (int j = 0; j < 7; j++) p[36 + 7*k + j] = code[6-j];
		end
		p[64] = 1'b1; p[65] = 1'b0; p[66] = 1'b1;
		build_pattern = p;
	endfunction

	// ---------------- geometry sequencer ----------------
	ean8r_pkg::state_t state_q, state_d;

	logic             valid_q;		// code passes the check
	logic [67:0]      pattern_q;
	logic [12:0]      w_q;			// clamped width, 1..4096
	logic [DIM_W-1:0] w_last_q;		// last column
	logic [DIM_W-1:0] h_last_q;		// last row
	logic [DIM_W-1:0] top_q;		// first bar row
	logic [DIM_W-1:0] top_end_q;		// first row below the bars
	logic [5:0]       t_q;			// clamped thickness, 1..63
	logic [EXT_W-1:0] ext_q;		// symbol width in pixels
	logic signed [OFF_W-1:0] left_q;	// left margin, may be negative

	// Divider: quotient < 67 and dividend < 67 * t, so 7 restoring steps.
	logic [EXT_W-1:0] rem_q;
	logic [MOD_W-1:0] quo_q;
	logic [2:0]       step_q;
	logic             second_q;		// 0: row-start offset, 1: current column

	logic [MOD_W-1:0] start_m_q;		// module at column 0
	logic [5:0]       start_ph_q;		// phase at column 0

	// Raster position and module tracking for the next pixel.
	logic [DIM_W-1:0]        col_q;
	logic [DIM_W-1:0]        row_q;
	logic signed [OFF_W-1:0] off_q;		// col - left
	logic [MOD_W-1:0]        m_q;		// module_index, 67 past the symbol
	logic [5:0]              ph_q;		// thickness_phase

	// Clamps for ST_GEOM.
	logic [12:0] w_c, h_c;
	logic [5:0]  t_c;
	logic [12:0] top_c;

	always_comb begin
		if (image_width_q == 13'd0)   w_c = 13'd1;
		else if (image_width_q > MAXD) w_c = MAXD;
		else                           w_c = image_width_q;
		if (image_height_q < BARH)      h_c = BARH;
		else if (image_height_q > MAXD) h_c = MAXD;
		else                            h_c = image_height_q;
		t_c   = (bar_thickness_q == 6'd0) ? 6'd1 : bar_thickness_q;
		top_c = (h_c - BARH) >> 1;
	end

	// Left margin: (w - extent) / 2 truncated toward zero.
	logic signed [OFF_W-1:0] diff_c, left_c, neg_left_c, pos_off_c;

	always_comb begin
		diff_c     = $signed({1'b0, w_q}) - $signed({1'b0, ext_q});
		left_c     = $signed(diff_c + OFF_W'(diff_c[OFF_W-1])) >>> 1;
		neg_left_c = -left_q;
		pos_off_c  = $signed({2'b00, col_q}) - left_q;
	end

	// One restoring division step.
	logic [EXT_W-1:0] trial_c, rem_c;
	logic [MOD_W-1:0] quo_c;
	logic             ge_c;

	always_comb begin
		trial_c = EXT_W'(t_q) << step_q;
		ge_c    = rem_q >= trial_c;
		rem_c   = ge_c ? rem_q - trial_c : rem_q;
		quo_c   = quo_q | (MOD_W'(ge_c) << step_q);
	end

	logic pos_neg_c, pos_past_c;
	assign pos_neg_c  = pos_off_c[OFF_W-1];
	assign pos_past_c = !pos_neg_c && (pos_off_c >= $signed({1'b0, ext_q}));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ean8r_pkg::ST_GEOM:  state_d = ean8r_pkg::ST_LEFT;
			ean8r_pkg::ST_LEFT:  state_d = ean8r_pkg::ST_START;
			ean8r_pkg::ST_START: state_d = ean8r_pkg::ST_DIV;
			ean8r_pkg::ST_DIV: begin
				if (step_q == 3'd0)
					state_d = second_q ? ean8r_pkg::ST_RUN : ean8r_pkg::ST_POS;
			end
			ean8r_pkg::ST_POS: begin
				state_d = (pos_neg_c || pos_past_c) ? ean8r_pkg::ST_RUN
					: ean8r_pkg::ST_DIV;
			end
			ean8r_pkg::ST_RUN:   state_d = ean8r_pkg::ST_RUN;
			default:             state_d = ean8r_pkg::ST_GEOM;
		endcase
		// any register write restarts the geometry
		if (cfg_we) state_d = ean8r_pkg::ST_GEOM;
	end

	// ---------------- pixel stage ----------------
	logic skid_valid_q;
	logic accept, push;

	// Outputs of the sequencer.
	always_comb begin
		s_tready = (state_q == ean8r_pkg::ST_RUN) && !skid_valid_q;
	end

	assign accept = s_tvalid && s_tready;
	assign push   = accept && s_tdata[0];

	logic inside_c, band_c, black_c, last_col_c, last_row_c;
	logic [2:0] word_c;	// {image_end, row_end, pixel_black} plus valid below

	always_comb begin
		inside_c   = !off_q[OFF_W-1] && (m_q < MOD_OUT);
		band_c     = (row_q >= top_q) && (row_q < top_end_q);
		black_c    = valid_q && inside_c && band_c && pattern_q[m_q];
		last_col_c = col_q >= w_last_q;
		last_row_c = row_q >= h_last_q;
		word_c     = {last_col_c && last_row_c, last_col_c, black_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ean8r_pkg::ST_GEOM;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			if (push) begin
				if (last_col_c) begin
					col_q <= '0;
					row_q <= last_row_c ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Geometry, divider and module tracking (no reset needed: rebuilt by the
	// sequencer before s_tready rises).
	always_ff @(posedge clk) begin
		unique case (state_q)
			ean8r_pkg::ST_GEOM: begin
				valid_q   <= code_check(code_digits_q);
				pattern_q <= build_pattern(code_digits_q);
				w_q       <= w_c;
				w_last_q  <= DIM_W'(w_c - 13'd1);
				h_last_q  <= DIM_W'(h_c - 13'd1);
				top_q     <= DIM_W'(top_c);
				top_end_q <= DIM_W'(top_c + BARH);
				t_q       <= t_c;
				ext_q     <= EXT_W'(t_c) * EXT_W'(ean8r_pkg::MODULES);
			end
			ean8r_pkg::ST_LEFT: begin
				left_q <= left_c;
			end
			ean8r_pkg::ST_START: begin
				rem_q    <= neg_left_c[OFF_W-1] ? '0 : neg_left_c[EXT_W-1:0];
				quo_q    <= '0;
				step_q   <= 3'(MOD_W - 1);
				second_q <= 1'b0;
			end
			ean8r_pkg::ST_DIV: begin
				rem_q  <= rem_c;
				quo_q  <= quo_c;
				step_q <= step_q - 3'd1;
				if (step_q == 3'd0) begin
					if (second_q) begin
						m_q  <= quo_c;
						ph_q <= rem_c[5:0];
					end else begin
						start_m_q  <= quo_c;
						start_ph_q <= rem_c[5:0];
					end
				end
			end
			ean8r_pkg::ST_POS: begin
				off_q    <= pos_off_c;
				rem_q    <= pos_off_c[EXT_W-1:0];
				quo_q    <= '0;
				step_q   <= 3'(MOD_W - 1);
				second_q <= 1'b1;
				if (pos_neg_c) begin
					m_q  <= '0;
					ph_q <= '0;
				end else if (pos_past_c) begin
					m_q  <= MOD_OUT;
					ph_q <= '0;
				end
			end
			ean8r_pkg::ST_RUN: begin
				if (push) begin
					if (last_col_c) begin
						off_q <= neg_left_c;
						m_q   <= start_m_q;
						ph_q  <= start_ph_q;
					end else begin
						off_q <= off_q + 1'b1;
						// step through the modules once the symbol has begun
						if (inside_c) begin
							if (ph_q == t_q - 6'd1) begin
								ph_q <= '0;
								m_q  <= m_q + 1'b1;
							end else begin
								ph_q <= ph_q + 6'd1;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// ---------------- output register with skid entry ----------------
	logic [3:0] main_q, skid_q;	// {image_end, code_valid, row_end, pixel_black}
	logic       main_valid_q;
	logic       pop;

	assign pop = main_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (push) begin
			if (main_valid_q && !pop) skid_valid_q <= 1'b1;
			else                      main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) main_q <= skid_q;
		end else if (push) begin
			if (main_valid_q && !pop)
				skid_q <= {word_c[2], valid_q, word_c[1:0]};
			else
				main_q <= {word_c[2], valid_q, word_c[1:0]};
		end
	end

	assign m_tvalid = main_valid_q;
	assign m_tdata  = {5'b00000, main_q[2:0]};
	assign m_tlast  = main_q[3];

endmodule
